### design/mbrx_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Shared types, codes and the CRC-16 byte update for the receiver blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrx_pkg;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [7:0]  ExcMask = 8'h7F;

    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] CFG_STATION   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FUNCTION  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FIXED_LEN = 2'd2;

    typedef enum logic {
        REQ_BYTE    = 1'b0,
        REQ_TIMEOUT = 1'b1
    } t_req_type;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_STATION = 3'd2,
        ST_FUNC    = 3'd3,
        ST_CRC     = 3'd4
    } t_status;

    typedef struct packed {
        t_req_type  req_type;
        logic [7:0] rx_byte;
    } t_in_req;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        t_status    status;
        logic [7:0] resp_function;
        logic       frame_last;
    } t_out_res;

    typedef struct packed {
        logic       is_timeout;
        logic [7:0] data;
    } t_item;

    function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/mbrx_front.sv
// ----------------------------------------------------------------------------
// Receiver front end
// Accepts requests, marks timeouts and queues them for the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire mbrx_pkg::t_in_req i_in,
    output logic                  o_q_valid,
    output mbrx_pkg::t_item       o_q_item,
    input  wire logic             i_q_pop
);
    import mbrx_pkg::*;

    t_item              r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   n_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QPtrW-1:0]   n_rd_ptr;
    logic [QCntW-1:0]   r_count;
    logic [QCntW-1:0]   n_count;
    logic               push;
    t_item              new_item;

    assign o_in_stall = (r_count == QCntW'(QDepth));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    assign new_item.is_timeout = (i_in.req_type == REQ_TIMEOUT);
    assign new_item.data       = i_in.rx_byte;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QDepth))
        else $error("queue fill count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid)
        else $error("pop from empty queue");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !i_q_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not track a push");

endmodule

`default_nettype wire

### design/mbrx_back.sv
// ----------------------------------------------------------------------------
// Receiver frame engine
// Runs the frame state machine and CRC-16 check and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbrx_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [mbrx_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                          i_q_valid,
    input  wire mbrx_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mbrx_pkg::t_out_res                 o_out
);
    import mbrx_pkg::*;

    typedef enum logic [6:0] {
        PH_STATION  = 7'b0000001,
        PH_FUNCTION = 7'b0000010,
        PH_COUNT    = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_CRC_LO   = 7'b0010000,
        PH_CRC_HI   = 7'b0100000,
        PH_DRAIN    = 7'b1000000
    } t_phase;

    logic [7:0]  r_exp_station;
    logic [6:0]  r_exp_function;
    logic [7:0]  r_fixed_len;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_rem;
    logic [7:0]  n_rem;
    logic [7:0]  r_pos;
    logic [7:0]  n_pos;
    logic [7:0]  r_crc_lo;
    logic [7:0]  n_crc_lo;
    logic [7:0]  r_func;
    logic [7:0]  n_func;

    logic        r_out_valid;
    t_out_res    r_out;

    logic        pop;
    logic        emit;
    t_out_res    res;
    logic [15:0] crc_upd;
    logic [7:0]  len;
    logic [7:0]  rem_dec;
    logic [7:0]  b;

    assign b       = i_q_item.data;
    assign pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign crc_upd = crc_next((r_phase == PH_STATION) ? CrcInit : r_crc, b);
    assign len     = (b > ExcMask) ? 8'd1 : r_fixed_len;
    assign rem_dec = r_rem - 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_rem    = r_rem;
        n_pos    = r_pos;
        n_crc_lo = r_crc_lo;
        n_func   = r_func;
        emit     = 1'b0;
        res      = '{out_kind: KIND_END, payload_byte: 8'h00, byte_index: 8'h00,
                     status: ST_OK, resp_function: 8'h00, frame_last: 1'b1};
        if (pop) begin
            if (i_q_item.is_timeout) begin
                n_phase = PH_STATION;
                n_crc   = CrcInit;
                if (r_phase != PH_DRAIN) begin
                    emit       = 1'b1;
                    res.status = ST_TIMEOUT;
                end
            end else begin
                unique case (r_phase)
                    PH_STATION: begin
                        n_crc  = crc_upd;
                        n_pos  = 8'h00;
                        n_func = 8'h00;
                        n_rem  = 8'h00;
                        if (b != r_exp_station) begin
                            n_phase    = PH_DRAIN;
                            emit       = 1'b1;
                            res.status = ST_STATION;
                        end else begin
                            n_phase = PH_FUNCTION;
                        end
                    end
                    PH_FUNCTION: begin
                        n_crc  = crc_upd;
                        n_func = b;
                        if ((b & ExcMask) != {1'b0, r_exp_function}) begin
                            n_phase    = PH_DRAIN;
                            emit       = 1'b1;
                            res.status = ST_FUNC;
                        end else if (len == 8'h00) begin
                            n_phase = PH_COUNT;
                        end else begin
                            n_rem   = len;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_COUNT: begin
                        n_crc   = crc_upd;
                        n_rem   = b;
                        n_phase = (b == 8'h00) ? PH_CRC_LO : PH_DATA;
                        n_pos   = r_pos + 1'b1;
                        emit    = 1'b1;
                        res.out_kind     = KIND_PAYLOAD;
                        res.payload_byte = b;
                        res.byte_index   = r_pos;
                        res.frame_last   = 1'b0;
                    end
                    PH_DATA: begin
                        n_crc = crc_upd;
                        n_rem = rem_dec;
                        if (rem_dec == 8'h00) begin
                            n_phase = PH_CRC_LO;
                        end
                        n_pos = r_pos + 1'b1;
                        emit  = 1'b1;
                        res.out_kind     = KIND_PAYLOAD;
                        res.payload_byte = b;
                        res.byte_index   = r_pos;
                        res.frame_last   = 1'b0;
                    end
                    PH_CRC_LO: begin
                        n_crc_lo = b;
                        n_phase  = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        emit = 1'b1;
                        if ({b, r_crc_lo} != r_crc) begin
                            n_phase    = PH_DRAIN;
                            res.status = ST_CRC;
                        end else begin
                            n_phase    = PH_STATION;
                            n_crc      = CrcInit;
                            res.status = ST_OK;
                        end
                    end
                    PH_DRAIN: begin
                        n_phase = PH_DRAIN;
                    end
                    default: begin
                        n_phase = PH_DRAIN;
                    end
                endcase
            end
        end
        res.resp_function = n_func;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_station  <= 8'd1;
            r_exp_function <= 7'd3;
            r_fixed_len    <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATION:   r_exp_station  <= i_cfg_data;
                CFG_FUNCTION:  r_exp_function <= i_cfg_data[6:0];
                CFG_FIXED_LEN: r_fixed_len    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STATION;
            r_crc       <= CrcInit;
            r_rem       <= 8'h00;
            r_pos       <= 8'h00;
            r_crc_lo    <= 8'h00;
            r_func      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_rem    <= n_rem;
            r_pos    <= n_pos;
            r_crc_lo <= n_crc_lo;
            r_func   <= n_func;
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out <= res;
        end
    end

    a_station_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_q_item.is_timeout && r_phase == PH_STATION && b != r_exp_station
        |=> r_phase == PH_DRAIN && r_out_valid && r_out.status == ST_STATION)
        else $error("station mismatch did not start a drop");

    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_q_item.is_timeout |=> r_phase == PH_STATION && r_crc == CrcInit)
        else $error("timeout did not return to idle");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.out_kind == KIND_PAYLOAD
        |-> r_out.status == ST_OK && !r_out.frame_last)
        else $error("payload result carries end report fields");

    a_crc_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_q_item.is_timeout && r_phase == PH_CRC_HI && {b, r_crc_lo} == r_crc
        |=> r_phase == PH_STATION && r_out_valid && r_out.status == ST_OK)
        else $error("good CRC did not end the frame");

endmodule

`default_nettype wire

### design/modbus_rtu_response_receiver_top.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver, top level
// Checks station, function and CRC-16 of a response and delivers its payload.
//
// Requests enter on i_in (a received byte or a line timeout) with
// i_in_valid, and are taken at an edge where o_in_stall is low. Results
// leave on o_out with o_out_valid and are taken at an edge where
// i_out_stall is low: a payload byte with its index, or a frame end report
// with its status. A request gives at most one result.
// Taken requests are queued and each result is registered for o_out. One
// request is processed per cycle unless a stalled result holds the output
// register; the combinational CRC byte update in the frame engine sets
// that rate. A two-entry queue between the front end and the frame engine
// lets requests keep coming while a result waits in the output register.
// When the receiver stalls, the output register holds, the queue fills and
// o_in_stall rises once it is full.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data. Reset
// restores expected station 1, function 3, fixed length 0, and waits for a
// station byte with the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_receiver_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbrx_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [mbrx_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire mbrx_pkg::t_in_req             i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mbrx_pkg::t_out_res                 o_out
);
    import mbrx_pkg::*;

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    mbrx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    mbrx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### bench/modbus_rtu_response_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver testbench
// Sends whole response frames, byte by byte, with line timeouts mixed in.
// Good, exception, CRC-damaged, wrong-station, wrong-function and truncated
// frames are used, and the settings change between phases. A scoreboard
// predicts every payload byte and frame end report, and checks each result
// the block delivers against that prediction. The sender idles and the
// receiver stalls at rates set for each phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver_top_tb;
    import mbrx_pkg::*;

    typedef enum logic [2:0] {
        RX_STATION,
        RX_FUNCTION,
        RX_COUNT,
        RX_DATA,
        RX_CRC_LO,
        RX_CRC_HI,
        RX_DROP
    } rx_state_e;

    class frame_scoreboard;
        logic [7:0]  station_cfg;
        logic [6:0]  function_cfg;
        logic [7:0]  length_cfg;
        rx_state_e   state;
        logic [15:0] crc;
        logic [7:0]  remaining;
        logic [7:0]  position;
        logic [7:0]  crc_lo;
        logic [7:0]  func_byte;
        t_out_res    expected[$];
        int          errors;

        function new();
            station_cfg  = 8'd1;
            function_cfg = 7'd3;
            length_cfg   = 8'd0;
            state        = RX_STATION;
            crc          = CrcInit;
            remaining    = 8'd0;
            position     = 8'd0;
            crc_lo       = 8'd0;
            func_byte    = 8'd0;
            errors       = 0;
        endfunction

        static function logic [15:0] crc16_update(input logic [15:0] c_in, input logic [7:0] b);
            logic [15:0] c;
            c = c_in ^ {8'h00, b};
            repeat (8) begin
                c = {1'b0, c[15:1]} ^ (c[0] ? CrcPoly : 16'h0000);
            end
            return c;
        endfunction

        function void set_config(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
            case (idx)
                CFG_STATION:   station_cfg  = data;
                CFG_FUNCTION:  function_cfg = data[6:0];
                CFG_FIXED_LEN: length_cfg   = data;
                default: ;
            endcase
        endfunction

        function void push_end(input t_status s);
            t_out_res r;
            r.out_kind      = KIND_END;
            r.payload_byte  = 8'd0;
            r.byte_index    = 8'd0;
            r.status        = s;
            r.resp_function = func_byte;
            r.frame_last    = 1'b1;
            expected.push_back(r);
        endfunction

        function void push_payload(input logic [7:0] b);
            t_out_res r;
            r.out_kind      = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.byte_index    = position;
            r.status        = ST_OK;
            r.resp_function = func_byte;
            r.frame_last    = 1'b0;
            expected.push_back(r);
            position = position + 8'd1;
        endfunction

        function void note_request(input t_in_req req);
            logic [7:0] b;
            logic [7:0] len;
            b = req.rx_byte;
            if (req.req_type == REQ_TIMEOUT) begin
                if (state != RX_DROP) begin
                    push_end(ST_TIMEOUT);
                end
                state = RX_STATION;
                crc   = CrcInit;
                return;
            end
            case (state)
                RX_STATION: begin
                    crc       = crc16_update(CrcInit, b);
                    position  = 8'd0;
                    func_byte = 8'd0;
                    remaining = 8'd0;
                    if (b != station_cfg) begin
                        state = RX_DROP;
                        push_end(ST_STATION);
                    end else begin
                        state = RX_FUNCTION;
                    end
                end
                RX_FUNCTION: begin
                    len       = length_cfg;
                    crc       = crc16_update(crc, b);
                    func_byte = b;
                    if (b[7]) begin
                        len = 8'd1;
                    end
                    if (b[6:0] != function_cfg) begin
                        state = RX_DROP;
                        push_end(ST_FUNC);
                    end else if (len == 8'd0) begin
                        state = RX_COUNT;
                    end else begin
                        remaining = len;
                        state     = RX_DATA;
                    end
                end
                RX_COUNT: begin
                    crc       = crc16_update(crc, b);
                    remaining = b;
                    state     = (b == 8'd0) ? RX_CRC_LO : RX_DATA;
                    push_payload(b);
                end
                RX_DATA: begin
                    crc       = crc16_update(crc, b);
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) begin
                        state = RX_CRC_LO;
                    end
                    push_payload(b);
                end
                RX_CRC_LO: begin
                    crc_lo = b;
                    state  = RX_CRC_HI;
                end
                RX_CRC_HI: begin
                    if ({b, crc_lo} != crc) begin
                        state = RX_DROP;
                        push_end(ST_CRC);
                    end else begin
                        state = RX_STATION;
                        crc   = CrcInit;
                        push_end(ST_OK);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(input t_out_res got);
            t_out_res want;
            if (expected.size() == 0) begin
                report($sformatf("unexpected result %0h", got));
                return;
            end
            want = expected.pop_front();
            check_field("out_kind", 8'(got.out_kind), 8'(want.out_kind));
            check_field("payload_byte", got.payload_byte, want.payload_byte);
            check_field("byte_index", got.byte_index, want.byte_index);
            check_field("status", 8'(got.status), 8'(want.status));
            check_field("resp_function", got.resp_function, want.resp_function);
            check_field("frame_last", 8'(got.frame_last), 8'(want.frame_last));
        endtask
    endclass

    logic               i_clk;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx    = CFG_STATION;
    logic [7:0]         cfg_data   = 8'd0;
    logic               in_valid   = 1'b0;
    t_in_req            in_req     = '0;
    logic               out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_res           o_out;

    int                 in_idle_pct   = 0;
    int                 out_stall_pct = 0;
    int                 items_sent    = 0;
    frame_scoreboard    sb;

    modbus_rtu_response_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                sb.check_result(o_out);
            end
            if (in_valid && !o_in_stall) begin
                sb.note_request(in_req);
            end
        end
    end

    task send_req(input t_req_type kind, input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{req_type: kind, rx_byte: b};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task send_timeout();
        send_req(REQ_TIMEOUT, 8'($urandom));
        items_sent++;
    endtask

    task send_junk_then_timeout();
        repeat ($urandom_range(3)) send_req(REQ_BYTE, 8'($urandom));
        send_timeout();
    endtask

    task send_frame(input logic [7:0] bytes[$], input bit bad_crc);
        logic [15:0] c;
        c = CrcInit;
        foreach (bytes[i]) c = frame_scoreboard::crc16_update(c, bytes[i]);
        if (bad_crc) begin
            c = c ^ (16'h0001 << $urandom_range(15));
        end
        foreach (bytes[i]) send_req(REQ_BYTE, bytes[i]);
        send_req(REQ_BYTE, c[7:0]);
        send_req(REQ_BYTE, c[15:8]);
        items_sent += bytes.size() + 2;
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_config(input logic [7:0] station, input logic [7:0] func, input logic [7:0] len);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_STATION;
        cfg_data <= station;
        @(posedge i_clk);
        cfg_idx  <= CFG_FUNCTION;
        cfg_data <= func;
        @(posedge i_clk);
        cfg_idx  <= CFG_FIXED_LEN;
        cfg_data <= len;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_config(CFG_STATION, station);
        sb.set_config(CFG_FUNCTION, func);
        sb.set_config(CFG_FIXED_LEN, len);
    endtask

    task random_frame(input logic [7:0] station, input logic [6:0] func, input logic [7:0] len);
        logic [7:0] q[$];
        logic [7:0] f;
        int         sel;
        int         n;
        int         r;
        bit         bad;
        sel = $urandom_range(99);
        q.push_back(station);
        if (sel < 14) begin
            q.push_back({1'b1, func});
            q.push_back(8'($urandom));
            bad = ($urandom_range(9) == 0);
            send_frame(q, bad);
            if (bad) begin
                send_junk_then_timeout();
            end
        end else if (sel < 80 || (sel >= 92 && sel < 97)) begin
            q.push_back({1'b0, func});
            if (len == 8'd0) begin
                r = $urandom_range(99);
                if (r == 0) begin
                    n = $urandom_range(255, 200);
                end else if (r < 10) begin
                    n = 0;
                end else begin
                    n = $urandom_range(8, 1);
                end
                q.push_back(8'(n));
            end else begin
                n = len;
            end
            repeat (n) q.push_back(8'($urandom));
            if (sel >= 92) begin
                n = $urandom_range(q.size(), 1);
                for (int i = 0; i < n; i++) send_req(REQ_BYTE, q[i]);
                items_sent += n;
                send_timeout();
            end else begin
                bad = (sel >= 70);
                send_frame(q, bad);
                if (bad) begin
                    send_junk_then_timeout();
                end
            end
        end else if (sel < 86) begin
            send_req(REQ_BYTE, station ^ 8'($urandom_range(255, 1)));
            items_sent++;
            send_junk_then_timeout();
        end else if (sel < 92) begin
            do begin
                f = 8'($urandom);
            end while (f[6:0] == func);
            send_req(REQ_BYTE, station);
            send_req(REQ_BYTE, f);
            items_sent += 2;
            send_junk_then_timeout();
        end else begin
            send_timeout();
        end
    endtask

    task run_phase(input bit do_write, input logic [7:0] station, input logic [7:0] func,
                   input logic [7:0] len, input int in_pct, input int out_pct, input int budget);
        if (do_write) begin
            write_config(station, func, len);
        end
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        items_sent    = 0;
        while (items_sent < budget) random_frame(station, func[6:0], len);
        wait_idle();
    endtask

    task directed_frames();
        send_timeout();
        send_frame('{8'h01, 8'h03, 8'h00}, 1'b0);
        send_req(REQ_BYTE, 8'hFF);
        send_req(REQ_BYTE, 8'h01);
        send_timeout();
        send_req(REQ_BYTE, 8'h01);
        send_req(REQ_BYTE, 8'h7F);
        send_timeout();
        send_frame('{8'h01, 8'h83, 8'hFF}, 1'b0);
        send_frame('{8'h01, 8'h03, 8'h01, 8'h00}, 1'b1);
        send_timeout();
        send_req(REQ_BYTE, 8'h01);
        send_req(REQ_BYTE, 8'h03);
        send_timeout();
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        directed_frames();
        run_phase(1'b0, 8'h01, 8'h03, 8'd0, 0, 0, 110);
        run_phase(1'b1, 8'h00, 8'h00, 8'd0, 88, 0, 130);
        run_phase(1'b1, 8'hFF, 8'hFF, 8'd0, 0, 88, 130);
        run_phase(1'b1, 8'h11, 8'h04, 8'd1, 27, 27, 120);
        run_phase(1'b1, 8'hA5, 8'h10, 8'd255, 0, 0, 180);
        run_phase(1'b1, 8'h01, 8'h83, 8'd5, 88, 0, 120);
        run_phase(1'b1, 8'h7E, 8'h2B, 8'd0, 0, 88, 120);
        run_phase(1'b1, 8'h5A, 8'h06, 8'd0, 27, 27, 100);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
